@@ rtl/lcw_pkg.sv @@
package lcw_pkg;

	localparam int unsigned COLOR_W     = 32;
	localparam int unsigned RGB_W       = 24;
	localparam int unsigned TIME_W      = 32;
	localparam int unsigned RUN_W       = 16;
	localparam int unsigned ENTRY_W     = 49;
	localparam int unsigned PAL_SLOTS   = 4;
	localparam int unsigned PAL_IDX_W   = 2;
	localparam int unsigned SIZE_W      = 3;
	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned LED_INDEX_W = 6;
	localparam int unsigned QUEUE_DEPTH = 2;

	// palette entry layout
	localparam int unsigned ENTRY_RAND_BIT = 32;
	localparam int unsigned ENTRY_RUN_LSB  = 33;

	localparam logic [TIME_W-1:0]  STEP_INTERVAL_RESET = 32'd100;
	localparam logic [ENTRY_W-1:0] PAL_RESET           = 49'h0_0003_FFFF_FFFF;
	localparam logic [SIZE_W-1:0]  PAL_SIZE_RESET      = 3'd1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_STEP_INTERVAL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REVERSE       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PALETTE_SIZE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PALETTE_0     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PALETTE_1     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PALETTE_2     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PALETTE_3     = 3'd6;

	typedef struct packed {
		logic [TIME_W-1:0] now_ms;
		logic [RGB_W-1:0]  random_rgb;
	} tick_t;

	typedef struct packed {
		logic [LED_INDEX_W-1:0] led_index;
		logic [7:0]             red;
		logic [7:0]             green;
		logic [7:0]             blue;
		logic [7:0]             white;
		logic                   last_led;
	} led_t;

	typedef struct packed {
		logic                 en;
		logic [CFG_IDX_W-1:0] index;
		logic [ENTRY_W-1:0]   data;
	} cfg_write_t;

	// one wipe step for the back end
	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic               reverse;
	} wipe_cmd_t;

	typedef struct packed {
		logic      valid;
		wipe_cmd_t cmd;
	} queue_port_t;

	typedef enum logic {
		BK_IDLE,
		BK_EMIT
	} bk_state_t;

endpackage

@@ rtl/lcw_queue.sv @@
module lcw_queue
	import lcw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  queue_port_t push,
	output logic        full,
	input  logic        pop,
	output queue_port_t head
);

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

	wipe_cmd_t        slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.cmd   = slot_q[rd_ptr_q];
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push.cmd;
		end
	end

endmodule

@@ rtl/lcw_front.sv @@
module lcw_front
	import lcw_pkg::*;
#(
	parameter int unsigned MAX_COLORS = 4
)(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_write_t  cfg,
	input  logic        in_valid,
	output logic        in_stall,
	input  tick_t       in_data,
	output queue_port_t push,
	input  logic        queue_full
);

	logic [TIME_W-1:0]    interval_q;
	logic                 reverse_q;
	logic [SIZE_W-1:0]    size_q;
	logic [ENTRY_W-1:0]   pal_q [PAL_SLOTS];
	logic [PAL_SLOTS-1:0] pal_rand_q;
	logic [RGB_W-1:0]     rep_q [PAL_SLOTS];
	logic [PAL_SLOTS-1:0] rep_flag_q;
	logic [TIME_W-1:0]    last_step_q;
	logic [PAL_IDX_W-1:0] pal_idx_q;
	logic [RUN_W-1:0]     run_cnt_q;

	logic                 accept;
	logic                 step;
	logic [TIME_W-1:0]    elapsed;
	logic [SIZE_W-1:0]    size_used;
	logic [PAL_IDX_W-1:0] idx;
	logic [PAL_IDX_W-1:0] nidx;
	logic [ENTRY_W-1:0]   entry;
	logic [COLOR_W-1:0]   color;
	logic [RUN_W:0]       run_next;
	logic                 run_done;
	logic [PAL_IDX_W-1:0] cfg_slot;
	logic                 cfg_slot_ok;

	assign in_stall = queue_full;
	assign accept   = in_valid && !queue_full;
	assign elapsed  = in_data.now_ms - last_step_q;
	assign step     = accept && (elapsed >= interval_q);

	always_comb begin
		if (size_q == '0) begin
			size_used = SIZE_W'(1);
		end else if (size_q > SIZE_W'(MAX_COLORS)) begin
			size_used = SIZE_W'(MAX_COLORS);
		end else begin
			size_used = size_q;
		end
	end

	// index left past the end by a smaller palette restarts at entry zero
	assign idx   = ({1'b0, pal_idx_q} >= size_used) ? '0 : pal_idx_q;
	assign entry = pal_q[idx];
	assign color = rep_flag_q[idx] ? {entry[COLOR_W-1:RGB_W], rep_q[idx]} : entry[COLOR_W-1:0];

	assign run_next = {1'b0, run_cnt_q} + 1'b1;
	assign run_done = run_next >= {1'b0, entry[ENTRY_RUN_LSB +: RUN_W]};
	assign nidx     = (({1'b0, idx} + 1'b1) == size_used) ? '0 : idx + 1'b1;

	assign push.valid       = step;
	assign push.cmd.color   = color;
	assign push.cmd.reverse = reverse_q;

	assign cfg_slot    = PAL_IDX_W'(cfg.index - REG_PALETTE_0);
	assign cfg_slot_ok = ({1'b0, cfg_slot} < SIZE_W'(MAX_COLORS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q  <= STEP_INTERVAL_RESET;
			reverse_q   <= 1'b0;
			size_q      <= PAL_SIZE_RESET;
			for (int k = 0; k < PAL_SLOTS; k++) begin
				pal_q[k] <= PAL_RESET;
			end
			pal_rand_q  <= '1;
			rep_flag_q  <= '0;
			last_step_q <= '0;
			pal_idx_q   <= '0;
			run_cnt_q   <= '0;
		end else begin
			if (step) begin
				last_step_q <= in_data.now_ms;
				if (run_done) begin
					run_cnt_q <= '0;
					pal_idx_q <= nidx;
					if (pal_rand_q[nidx]) begin
						rep_flag_q[nidx] <= 1'b1;
					end
				end else begin
					run_cnt_q <= run_next[RUN_W-1:0];
					pal_idx_q <= idx;
				end
			end
			if (cfg.en) begin
				case (cfg.index)
					REG_STEP_INTERVAL: interval_q <= cfg.data[TIME_W-1:0];
					REG_REVERSE:       reverse_q  <= cfg.data[0];
					REG_PALETTE_SIZE:  size_q     <= cfg.data[SIZE_W-1:0];
					REG_PALETTE_0, REG_PALETTE_1, REG_PALETTE_2, REG_PALETTE_3: begin
						if (cfg_slot_ok) begin
							pal_q[cfg_slot]      <= cfg.data;
							pal_rand_q[cfg_slot] <= cfg.data[ENTRY_RAND_BIT];
							// a rewritten entry falls back to its own rgb
							rep_flag_q[cfg_slot] <= 1'b0;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// replacement colors are only read while their flag is set
	always_ff @(posedge clk) begin
		if (step && run_done && pal_rand_q[nidx]) begin
			rep_q[nidx] <= in_data.random_rgb;
		end
	end

endmodule

@@ rtl/lcw_back.sv @@
module lcw_back
	import lcw_pkg::*;
#(
	parameter int unsigned LED_COUNT = 32
)(
	input  logic        clk,
	input  logic        arst_n,
	input  queue_port_t head,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output led_t        out_data
);

	localparam int unsigned LED_IDX_W = $clog2(LED_COUNT);
	localparam logic [LED_IDX_W-1:0] LAST_IDX = LED_IDX_W'(LED_COUNT - 1);

	logic [COLOR_W-1:0]   strip_q [LED_COUNT];
	bk_state_t            state_q;
	bk_state_t            state_d;
	logic [LED_IDX_W-1:0] cnt_q;
	logic                 out_valid_q;
	led_t                 out_q;
	logic                 advance;
	logic                 at_last;

	assign at_last = (cnt_q == LAST_IDX);

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (head.valid) begin
					state_d = BK_EMIT;
				end
			end
			BK_EMIT: begin
				if (advance && at_last) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop     = 1'b0;
		advance = 1'b0;
		case (state_q)
			BK_IDLE: pop     = head.valid;
			BK_EMIT: advance = !out_valid_q || !out_stall;
			default: ;
		endcase
	end

	// strip is a ring: emission rotates it once, ending where it began
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < LED_COUNT; i++) begin
				strip_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (pop) begin
				cnt_q <= '0;
				if (head.cmd.reverse) begin
					for (int i = LED_COUNT - 1; i > 0; i--) begin
						strip_q[i] <= strip_q[i-1];
					end
					strip_q[0] <= head.cmd.color;
				end else begin
					for (int i = 0; i < LED_COUNT - 1; i++) begin
						strip_q[i] <= strip_q[i+1];
					end
					strip_q[LED_COUNT-1] <= head.cmd.color;
				end
			end else if (advance) begin
				cnt_q <= cnt_q + 1'b1;
				for (int i = 0; i < LED_COUNT - 1; i++) begin
					strip_q[i] <= strip_q[i+1];
				end
				strip_q[LED_COUNT-1] <= strip_q[0];
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.led_index <= LED_INDEX_W'(cnt_q);
			out_q.red       <= strip_q[0][7:0];
			out_q.green     <= strip_q[0][15:8];
			out_q.blue      <= strip_q[0][23:16];
			out_q.white     <= strip_q[0][31:24];
			out_q.last_led  <= at_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ rtl/led_strip_color_wipe.sv @@
// path: a stepping tick is queued, loaded in BK_IDLE, then emitted from BK_EMIT
// throughput: one tick per cycle while the command queue has room; each step then
//   holds the back end for one load, then one led per cycle out of the strip ring
//   while not stalled; the next command pops only after the frame is out
// reset: arst_n clears strip, timing, palette position and queue; config to defaults
module led_strip_color_wipe
	import lcw_pkg::*;
#(
	parameter int unsigned LED_COUNT  = 32,
	parameter int unsigned MAX_COLORS = 4
)(
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write port
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ENTRY_W-1:0]   cfg_data,
	// tick input
	input  logic                 in_valid,
	output logic                 in_stall,
	input  tick_t                in_data,
	// led output, one transaction per led
	output logic                 out_valid,
	input  logic                 out_stall,
	output led_t                 out_data
);

	cfg_write_t  cfg;
	queue_port_t push;
	queue_port_t head;
	logic        queue_full;
	logic        pop;

	assign cfg.en    = cfg_wr_en;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	// front end: interval check, palette walk and random replacement,
	// produces the color that enters the strip on this step
	lcw_front #(
		.MAX_COLORS (MAX_COLORS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.push       (push),
		.queue_full (queue_full)
	);

	// short command queue so ticks keep flowing while a frame drains
	lcw_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (queue_full),
		.pop    (pop),
		.head   (head)
	);

	// back end: shifts the strip and streams the whole frame out
	lcw_back #(
		.LED_COUNT (LED_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

@@ rtl/lcw_checker.sv @@
module lcw_checker
	import lcw_pkg::*;
#(
	parameter int unsigned LED_COUNT = 32
)(
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input led_t out_data
);

	// a held led stays put until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("led output changed while stalled");

	// a frame streams without gaps once started
	a_frame_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_data.last_led |=> out_valid)
		else $error("gap inside a frame");

	// leds come out in index order
	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_data.last_led |=>
		out_data.led_index == LED_INDEX_W'($past(out_data.led_index) + 1'b1))
		else $error("led index out of order");

	// the last flag marks the top led only
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.last_led == (out_data.led_index == LED_INDEX_W'(LED_COUNT - 1))))
		else $error("last_led on wrong led");

endmodule

bind led_strip_color_wipe lcw_checker #(
	.LED_COUNT (LED_COUNT)
) u_lcw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
